### sv/mbpe_pkg.sv
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander package
// Display size, register indexes and the types shared between the modules.
// ----------------------------------------------------------------------------
package mbpe_pkg;

   localparam int DISPLAY_WIDTH  = 320;
   localparam int DISPLAY_HEIGHT = 480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [11:0] DISP_W = 12'(DISPLAY_WIDTH);
   localparam logic [11:0] DISP_H = 12'(DISPLAY_HEIGHT);

   localparam logic [7:0] LEFT_BIT  = 8'h80;
   localparam logic [3:0] MAX_PIXELS = 4'd8;

   typedef enum logic [2:0] {
      CSR_START_X     = 3'd0,
      CSR_START_Y     = 3'd1,
      CSR_RECT_WIDTH  = 3'd2,
      CSR_RECT_HEIGHT = 3'd3,
      CSR_FG_COLOR    = 3'd4,
      CSR_BG_COLOR    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [9:0]  start_x;
      logic [9:0]  start_y;
      logic [9:0]  rect_width;
      logic [9:0]  rect_height;
      logic [15:0] fg_color;
      logic [15:0] bg_color;
   } cfg_type;

   typedef struct packed {
      logic [7:0] bits;
      logic [3:0] count;
      logic       last_glyph;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### sv/mbpe_ifs.sv
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander channels
// Valid/ready channels for bitmap requests, pixel results and register writes.
// ----------------------------------------------------------------------------
interface mbpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] bitmap_byte;
   modport source (output valid, output bitmap_byte, input ready);
   modport sink (input valid, input bitmap_byte, output ready);
endinterface

interface mbpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_color;
   logic        last_of_byte;
   logic        last_of_glyph;
   modport source (output valid, output pixel_color, output last_of_byte,
                   output last_of_glyph, input ready);
   modport sink (input valid, input pixel_color, input last_of_byte,
                 input last_of_glyph, output ready);
endinterface

interface mbpe_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### sv/mbpe_csr.sv
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander registers
// Holds the rectangle and colour settings and flags every write.
// ----------------------------------------------------------------------------
module mbpe_csr
   import mbpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mbpe_csr_if.sink   csr_chan,
   output cfg_type    cfg,
   output logic       cfg_write
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg_write      = csr_chan.valid;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_START_X:     cfg_in.start_x     = csr_chan.data[9:0];
            CSR_START_Y:     cfg_in.start_y     = csr_chan.data[9:0];
            CSR_RECT_WIDTH:  cfg_in.rect_width  = csr_chan.data[9:0];
            CSR_RECT_HEIGHT: cfg_in.rect_height = csr_chan.data[9:0];
            CSR_FG_COLOR:    cfg_in.fg_color    = csr_chan.data;
            CSR_BG_COLOR:    cfg_in.bg_color    = csr_chan.data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x     <= 10'd0;
         cfg_ff.start_y     <= 10'd0;
         cfg_ff.rect_width  <= 10'd8;
         cfg_ff.rect_height <= 10'd8;
         cfg_ff.fg_color    <= 16'hFFFF;
         cfg_ff.bg_color    <= 16'h0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/mbpe_front.sv
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander front end
// Tracks the glyph position, clips each byte and queues the visible pixels.
// ----------------------------------------------------------------------------
module mbpe_front
   import mbpe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   mbpe_req_if.sink         req_chan,
   input  cfg_type          cfg,
   input  logic             cfg_write,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   logic [9:0]  column_pos_ff, column_pos_in;
   logic [9:0]  row_pos_ff, row_pos_in;
   logic        accept;
   logic        dims_ok;
   logic [11:0] col12, next_col, edge_x, avail_w, avail_d, lim;
   logic [10:0] row_p1;
   logic        col_wrap, row_wrap, on_screen, row_vis;
   logic [3:0]  count;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      dims_ok   = (cfg.rect_width != 10'd0) && (cfg.rect_height != 10'd0);
      col12     = {2'b00, column_pos_ff};
      next_col  = col12 + 12'd8;
      row_p1    = {1'b0, row_pos_ff} + 11'd1;
      col_wrap  = next_col >= {2'b00, cfg.rect_width};
      row_wrap  = row_p1 >= {1'b0, cfg.rect_height};
      on_screen = ({2'b00, cfg.start_x} < DISP_W) && ({2'b00, cfg.start_y} < DISP_H);
      row_vis   = (row_pos_ff < cfg.rect_height)
                  && (({2'b00, cfg.start_y} + {2'b00, row_pos_ff}) < DISP_H);
      avail_w   = (column_pos_ff < cfg.rect_width)
                  ? ({2'b00, cfg.rect_width} - col12) : 12'd0;
      edge_x    = {2'b00, cfg.start_x} + col12;
      avail_d   = (edge_x < DISP_W) ? (DISP_W - edge_x) : 12'd0;
      lim       = (avail_w < avail_d) ? avail_w : avail_d;
      count     = (lim < {8'd0, MAX_PIXELS}) ? lim[3:0] : MAX_PIXELS;
      if (!(dims_ok && on_screen && row_vis)) begin
         count = 4'd0;
      end
   end

   assign push                = accept && (count != 4'd0);
   assign push_job.bits       = req_chan.bitmap_byte;
   assign push_job.count      = count;
   assign push_job.last_glyph = col_wrap && row_wrap;

   always_comb begin
      column_pos_in = column_pos_ff;
      row_pos_in    = row_pos_ff;
      if (cfg_write) begin
         column_pos_in = 10'd0;
         row_pos_in    = 10'd0;
      end else if (accept) begin
         if (!dims_ok) begin
            column_pos_in = 10'd0;
            row_pos_in    = 10'd0;
         end else if (col_wrap) begin
            column_pos_in = 10'd0;
            row_pos_in    = row_wrap ? 10'd0 : row_p1[9:0];
         end else begin
            column_pos_in = next_col[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= 10'd0;
         row_pos_ff    <= 10'd0;
      end else begin
         column_pos_ff <= column_pos_in;
         row_pos_ff    <= row_pos_in;
      end
   end

endmodule

### sv/mbpe_queue.sv
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander job queue
// A short register queue between the front end and the pixel back end.
// ----------------------------------------------------------------------------
module mbpe_queue
   import mbpe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;

   assign head_job       = slot_ff[rd_ptr_ff];
   assign q_status.full  = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = fill_ff == '0;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### sv/mbpe_back.sv
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander back end
// Shifts out one pixel colour per cycle from the queued jobs unless stalled.
// ----------------------------------------------------------------------------
module mbpe_back
   import mbpe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             pop,
   mbpe_rsp_if.source       rsp_chan
);

   logic        cur_valid_ff, cur_valid_in;
   logic [7:0]  cur_bits_ff, cur_bits_in;
   logic [3:0]  cur_left_ff, cur_left_in;
   logic        cur_glyph_ff, cur_glyph_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_color_ff, out_color_in;
   logic        out_lob_ff, out_lob_in;
   logic        out_log_ff, out_log_in;
   logic        advance, finishing;

   assign advance   = !out_valid_ff || rsp_chan.ready;
   assign finishing = cur_valid_ff && advance && (cur_left_ff == 4'd1);
   assign pop       = !q_status.empty && (!cur_valid_ff || finishing);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_bits_in  = cur_bits_ff;
      cur_left_in  = cur_left_ff;
      cur_glyph_in = cur_glyph_ff;
      out_valid_in = out_valid_ff;
      out_color_in = out_color_ff;
      out_lob_in   = out_lob_ff;
      out_log_in   = out_log_ff;
      if (advance) begin
         out_valid_in = cur_valid_ff;
         out_color_in = ((cur_bits_ff & LEFT_BIT) != 8'd0) ? cfg.fg_color : cfg.bg_color;
         out_lob_in   = cur_left_ff == 4'd1;
         out_log_in   = cur_glyph_ff;
         if (cur_valid_ff) begin
            cur_bits_in = {cur_bits_ff[6:0], 1'b0};
            cur_left_in = cur_left_ff - 4'd1;
         end
      end
      if (finishing) begin
         cur_valid_in = 1'b0;
      end
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_bits_in  = head_job.bits;
         cur_left_in  = head_job.count;
         cur_glyph_in = head_job.last_glyph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bits_ff  <= cur_bits_in;
      cur_left_ff  <= cur_left_in;
      cur_glyph_ff <= cur_glyph_in;
      out_color_ff <= out_color_in;
      out_lob_ff   <= out_lob_in;
      out_log_ff   <= out_log_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pixel_color   = out_color_ff;
   assign rsp_chan.last_of_byte  = out_lob_ff;
   assign rsp_chan.last_of_glyph = out_log_ff;

endmodule

### sv/mono_bitmap_pixel_expander.sv
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander
// Expands one-bit glyph bytes into clipped RGB565 pixel colours.
//
//   Channel    Direction  Payload
//   req_chan   in         bitmap_byte
//   rsp_chan   out        pixel_color, last_of_byte, last_of_glyph
//   csr_chan   in         index, data (register write)
//
// A request is taken whenever the four-entry job queue has room. While the output
// is not stalled, the pixel back end delivers one pixel per cycle, one for each
// visible pixel of a byte; a fully clipped byte is taken without being queued
// and produces no pixel.
// Reset is synchronous and restores the register defaults and empties the queue.
// A stalled response holds in the output register while requests keep queueing.
// ----------------------------------------------------------------------------
module mono_bitmap_pixel_expander
   import mbpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mbpe_req_if.sink    req_chan,
   mbpe_rsp_if.source  rsp_chan,
   mbpe_csr_if.sink    csr_chan
);

   cfg_type          cfg;
   logic             cfg_write;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type q_status;

   mbpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .cfg       (cfg),
      .cfg_write (cfg_write)
   );

   mbpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .cfg_write (cfg_write),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   mbpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   mbpe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("Job pushed into a full queue.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("Job popped from an empty queue.");

   a_job_has_pixels: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.count != 4'd0 && push_job.count <= MAX_PIXELS))
      else $error("Queued job carries an impossible pixel count.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("Response valid straight after reset.");

endmodule
